// File: hw/rtl/wfa_pkg.sv
// Shared types and constants for the worst-fit bin allocator.
// Used by wfa_ctrl, wfa_dp and worst_fit_max_heap_allocator_top; no dependencies.
package wfa_pkg;

  localparam int MAX_BINS_DEF = 64;
  localparam int CAP_BITS_DEF = 16;

  localparam int AMOUNT_W = 16;
  localparam int INDEX_W  = 6;
  localparam int CAPOUT_W = 17;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_ALLOC = 2'd1;
  localparam logic [1:0] ACT_DRAIN = 2'd2;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALLOC_SCAN,
    ST_ALLOC_DONE,
    ST_DRAIN_SCAN,
    ST_DRAIN_EMIT
  } wfa_state_t;

  typedef struct packed {
    logic load;          // append one bin
    logic scan_start;    // clear scan pointer and best candidate
    logic scan_run;      // issue reads and compare
    logic skip_taken;    // leave out bins already drained in this pass
    logic drain_start;   // clear taken flags and emit counter
    logic alloc_finish;  // write allocation answer, update capacity
    logic drain_emit;    // write drained bin, mark it exhausted
  } wfa_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic scan_done;
    logic last_emit;
    logic out_free;
  } wfa_sts_t;

endpackage

// File: hw/rtl/worst_fit_max_heap_allocator_top.sv
// Top level of the worst-fit bin allocator.
// Depends on wfa_pkg, wfa_ctrl and wfa_dp.
//
// Worst-fit bin allocator. Load transactions (action 0) append one bin with
// the given capacity; loads past MAX_BINS are dropped silently.
// Allocate (action 1) scans every loaded bin through the single read port of
// the capacity memory, one bin per cycle, picks the greatest remaining
// capacity (lowest index on ties) and answers with one transaction: the bin
// index and fits=1 after subtracting the request, or index 0 and fits=0.
// Drain (action 2) repeats that scan once per bin, skipping bins already
// emitted, and returns one transaction per loaded bin in descending capacity
// order with last set on the final one; exhausted bins report -1 and come
// after all live bins. A drain with no bins returns nothing. Every drained
// bin is exhausted from then on. One input transaction is worked on at a
// time; in_stall is low only while the sequencer is idle, and a finished
// result waits in the output register while the next input transaction is
// taken. Action code 3 is ignored.
module worst_fit_max_heap_allocator_top
  import wfa_pkg::*;
#(
  parameter int MAX_BINS = MAX_BINS_DEF,
  parameter int CAP_BITS = CAP_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_action,
  input  logic [AMOUNT_W-1:0]        in_amount,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_result_kind,
  output logic [INDEX_W-1:0]         out_bin_index,
  output logic                       out_fits,
  output logic signed [CAPOUT_W-1:0] out_capacity_out,
  output logic                       out_last
);

  wfa_cmd_t cmd;
  wfa_sts_t sts;

  // sequencer: decodes the action and steps the scan passes
  wfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_stall  (in_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // capacity memory, flags, compare unit and the output register
  wfa_dp #(
    .MAX_BINS (MAX_BINS),
    .CAP_BITS (CAP_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_amount        (in_amount),
    .cmd              (cmd),
    .sts              (sts),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_result_kind  (out_result_kind),
    .out_bin_index    (out_bin_index),
    .out_fits         (out_fits),
    .out_capacity_out (out_capacity_out),
    .out_last         (out_last)
  );

endmodule

// File: hw/rtl/wfa_ctrl.sv
// Sequencer for the worst-fit bin allocator: decodes transactions and steps scans.
// Depends on wfa_pkg; drives wfa_dp through wfa_cmd_t and reads wfa_sts_t.
module wfa_ctrl
  import wfa_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_action,
  output logic       in_stall,
  input  wfa_sts_t   sts,
  output wfa_cmd_t   cmd
);

  wfa_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          case (in_action)
            ACT_LOAD: begin
              cmd.load = 1'b1;
            end
            ACT_ALLOC: begin
              cmd.scan_start = 1'b1;
              state_nxt      = ST_ALLOC_SCAN;
            end
            ACT_DRAIN: begin
              if (!sts.count_zero) begin
                cmd.scan_start  = 1'b1;
                cmd.drain_start = 1'b1;
                state_nxt       = ST_DRAIN_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_ALLOC_SCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_done) begin
          state_nxt = ST_ALLOC_DONE;
        end
      end
      ST_ALLOC_DONE: begin
        if (sts.out_free) begin
          cmd.alloc_finish = 1'b1;
          state_nxt        = ST_IDLE;
        end
      end
      ST_DRAIN_SCAN: begin
        cmd.scan_run   = 1'b1;
        cmd.skip_taken = 1'b1;
        if (sts.scan_done) begin
          state_nxt = ST_DRAIN_EMIT;
        end
      end
      ST_DRAIN_EMIT: begin
        if (sts.out_free) begin
          cmd.drain_emit = 1'b1;
          if (sts.last_emit) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.scan_start = 1'b1;
            state_nxt      = ST_DRAIN_SCAN;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/wfa_dp.sv
// Datapath of the worst-fit bin allocator: capacity memory, flags, scan unit, output register.
// Depends on wfa_pkg; commanded by wfa_ctrl.
module wfa_dp
  import wfa_pkg::*;
#(
  parameter int MAX_BINS = MAX_BINS_DEF,
  parameter int CAP_BITS = CAP_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [AMOUNT_W-1:0]        in_amount,
  input  wfa_cmd_t                   cmd,
  output wfa_sts_t                   sts,
  input  logic                       out_stall,
  output logic                       out_valid,
  output logic                       out_result_kind,
  output logic [INDEX_W-1:0]         out_bin_index,
  output logic                       out_fits,
  output logic signed [CAPOUT_W-1:0] out_capacity_out,
  output logic                       out_last
);

  localparam int IDX_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int CNT_W = $clog2(MAX_BINS + 1);
  localparam int VAL_W = CAP_BITS + 1;
  localparam int CMP_W = (CAP_BITS > AMOUNT_W) ? CAP_BITS : AMOUNT_W;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BINS);

  logic [CAP_BITS-1:0] cap_mem [MAX_BINS];
  logic [CAP_BITS-1:0] rd_data_r;
  logic [IDX_W-1:0]    rd_addr;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  logic [CAP_BITS-1:0] wr_data;

  logic [CNT_W-1:0]    bin_count_r;
  logic [CNT_W-1:0]    emit_cnt_r;
  logic [MAX_BINS-1:0] exh_r;
  logic [MAX_BINS-1:0] taken_r;
  logic [AMOUNT_W-1:0] amount_r;

  logic [CNT_W-1:0]    ptr_r;
  logic                pipe_vld_r;
  logic [IDX_W-1:0]    pipe_idx_r;
  logic                pipe_exh_r;
  logic                pipe_skip_r;
  logic                best_found_r;
  logic signed [VAL_W-1:0] best_val_r;
  logic [IDX_W-1:0]    best_idx_r;

  logic                out_valid_r;
  logic                out_kind_r;
  logic [INDEX_W-1:0]  out_idx_r;
  logic                out_fits_r;
  logic signed [CAPOUT_W-1:0] out_cap_r;
  logic                out_last_r;

  logic signed [VAL_W-1:0] cand_val;
  logic                take;
  logic                can_load;
  logic [CAP_BITS-1:0] best_cap;
  logic                alloc_fit;
  logic [CNT_W-1:0]    emit_inc;

  assign rd_addr   = ptr_r[IDX_W-1:0];
  assign can_load  = cmd.load && (bin_count_r < MAX_CNT);
  assign best_cap  = best_val_r[CAP_BITS-1:0];
  assign alloc_fit = best_found_r && !best_val_r[VAL_W-1] &&
                     (CMP_W'(amount_r) <= CMP_W'(best_cap));
  assign emit_inc  = emit_cnt_r + 1'b1;

  // exhausted bins rank as -1, below every live capacity
  assign cand_val = pipe_exh_r ? '1 : $signed({1'b0, rd_data_r});
  assign take     = pipe_vld_r && !pipe_skip_r &&
                    (!best_found_r || (cand_val > best_val_r));

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = bin_count_r[IDX_W-1:0];
    wr_data = CAP_BITS'(in_amount);
    if (can_load) begin
      wr_en = 1'b1;
    end else if (cmd.alloc_finish && alloc_fit) begin
      wr_en   = 1'b1;
      wr_addr = best_idx_r;
      wr_data = CAP_BITS'(CMP_W'(best_cap) - CMP_W'(amount_r));
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cap_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= cap_mem[rd_addr];
  end

  // bin count, exhausted and taken flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_count_r <= '0;
      emit_cnt_r  <= '0;
      exh_r       <= '0;
      taken_r     <= '0;
    end else begin
      if (can_load) begin
        bin_count_r                     <= bin_count_r + 1'b1;
        exh_r[bin_count_r[IDX_W-1:0]]   <= 1'b0;
      end
      if (cmd.drain_start) begin
        taken_r    <= '0;
        emit_cnt_r <= '0;
      end
      if (cmd.drain_emit) begin
        exh_r[best_idx_r]   <= 1'b1;
        taken_r[best_idx_r] <= 1'b1;
        emit_cnt_r          <= emit_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start && !cmd.drain_emit) begin
      amount_r <= in_amount;
    end
  end

  // scan: one read issued per cycle, compared in the cycle after it is issued
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r        <= '0;
      pipe_vld_r   <= 1'b0;
      best_found_r <= 1'b0;
    end else if (cmd.scan_start) begin
      ptr_r        <= '0;
      pipe_vld_r   <= 1'b0;
      best_found_r <= 1'b0;
    end else if (cmd.scan_run) begin
      if (ptr_r < bin_count_r) begin
        pipe_vld_r <= 1'b1;
        ptr_r      <= ptr_r + 1'b1;
      end else begin
        pipe_vld_r <= 1'b0;
      end
      if (take) begin
        best_found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    pipe_idx_r  <= ptr_r[IDX_W-1:0];
    pipe_exh_r  <= exh_r[ptr_r[IDX_W-1:0]];
    pipe_skip_r <= cmd.skip_taken && taken_r[ptr_r[IDX_W-1:0]];
    if (cmd.scan_run && take) begin
      best_val_r <= cand_val;
      best_idx_r <= pipe_idx_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.alloc_finish || cmd.drain_emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.alloc_finish) begin
      out_kind_r <= KIND_ALLOC;
      out_idx_r  <= alloc_fit ? INDEX_W'(best_idx_r) : '0;
      out_fits_r <= alloc_fit;
      out_cap_r  <= '0;
      out_last_r <= 1'b1;
    end else if (cmd.drain_emit) begin
      out_kind_r <= KIND_DRAIN;
      out_idx_r  <= INDEX_W'(best_idx_r);
      out_fits_r <= 1'b0;
      out_cap_r  <= CAPOUT_W'(best_val_r);
      out_last_r <= sts.last_emit;
    end
  end

  assign sts.count_zero = (bin_count_r == '0);
  assign sts.scan_done  = (ptr_r >= bin_count_r) && !pipe_vld_r;
  assign sts.last_emit  = (emit_inc == bin_count_r);
  assign sts.out_free   = !out_valid_r || !out_stall;

  assign out_valid        = out_valid_r;
  assign out_result_kind  = out_kind_r;
  assign out_bin_index    = out_idx_r;
  assign out_fits         = out_fits_r;
  assign out_capacity_out = out_cap_r;
  assign out_last         = out_last_r;

`ifndef ASSERT_OFF
  a_full_load_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && bin_count_r == MAX_CNT) |=> $stable(bin_count_r))
    else $error("load into a full bin set changed the count");

  a_emit_marks_bin: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.drain_emit |=> (exh_r[$past(best_idx_r)] && taken_r[$past(best_idx_r)]))
    else $error("drained bin not marked exhausted and taken");

  a_emit_has_candidate: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.drain_emit |-> best_found_r)
    else $error("drain emitted without a scanned candidate");

  a_emit_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    emit_cnt_r <= bin_count_r)
    else $error("more drained results than loaded bins");
`endif

endmodule
